// ===== hdl/hmn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hmn_pkg;

   // One normal pixel waiting to be computed.
   typedef struct packed {
      logic [9:0] pix_x;
      logic [9:0] pix_y;
      logic       last;
      logic [7:0] self_h;
      logic [7:0] right_h;
      logic [7:0] below_h;
   } job_type;

   // Number of candidate pixels that one input sample can finish.
   localparam int JOBS = 4;

   // (127 * 255)^2, the squared numerator of the blue channel.
   localparam logic [29:0] BLUE_NUM_SQ = 30'd1048788225;

   // 255^2, the fixed z term of every squared length.
   localparam logic [17:0] Z_SQ = 18'd65025;

   // Register indexes of the configuration port.
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/heightmap_to_normal_map_core.sv =====
// Height map to normal map, forward differences.
// Height bytes enter on the req_ channel in raster order, one item per
// accepted req_valid with req_stall low. Normal pixels leave on the rsp_
// channel with their column, row, packed ARGB word and an end-of-frame flag.
// A pixel leaves once the sample below it has arrived, so output lags input
// by one row; the last row drains as it is received.
// Each input item is accepted with the row store read, then updates the
// state in ST_READ, then goes through dispatch (ST_SEL); for each pixel it
// finishes it runs the setup states ST_PREP1 and ST_PREP2, an 8-step
// bit-serial square-root search that runs the three color channels side by
// side on one multiplier each, and the output register (ST_OUT), then
// returns to dispatch; the dispatch that finds nothing left goes idle.
// Items may finish no pixel, most items finish one, corner items up to four.
// req_stall is high while an item is being worked on.
// A stalled rsp_ holds its item and the block waits; nothing is dropped.
// Reset (synchronous, active high) sets the size to 1024 x 1024 and starts a
// new frame at row 0; the row store needs no clearing because every entry
// is written in one row before it is read in the next. A csr_ write to
// either size register also restarts the frame.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_to_normal_map_core #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_height_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [9:0]       rsp_pixel_x,
   output logic [9:0]       rsp_pixel_y,
   output logic [31:0]      rsp_normal_argb,
   output logic             rsp_frame_done,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_data
);
   import hmn_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_SEL    = 3'd2;
   localparam logic [2:0] ST_PREP1  = 3'd3;
   localparam logic [2:0] ST_PREP2  = 3'd4;
   localparam logic [2:0] ST_SEARCH = 3'd5;
   localparam logic [2:0] ST_OUT    = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [10:0]   width_ff, height_ff;
   logic [CW-1:0] col_ff, row_col_c;
   logic [9:0]    row_ff, row_c;
   logic [CW-1:0] w_last;
   logic [9:0]    h_last;

   logic [CW-1:0] c_ff;
   logic [9:0]    r_ff;
   logic [7:0]    sample_ff;
   logic [7:0]    above_ff;
   logic [7:0]    left_cur_ff;
   logic [7:0]    left_prev_ff;
   logic [7:0]    row_mem [MAX_WIDTH];

   job_type       jobs_ff [JOBS];
   logic [JOBS-1:0] pending_ff;
   job_type       cur_ff;
   logic [1:0]    pick;

   logic signed [8:0] dx, dy;
   logic [16:0]   dx2_ff, dy2_ff;
   logic [14:0]   mr_ff, mg_ff;
   logic [7:0]    alpha_ff;
   logic [17:0]   s_ff;
   logic [29:0]   nn_ff  [3];
   logic          neg_ff [3];
   logic [7:0]    acc_ff [3];
   logic [15:0]   accsq_ff [3];
   logic [15:0]   cand_sq [3];
   logic          cand_ok [3];
   logic [2:0]    step_ff;
   logic [7:0]    chan [3];
   logic [15:0]   alpha_p;

   logic          req_take;

   // Effective image size, clamped to the supported range.
   always_comb begin
      if (width_ff == 11'd0) begin
         w_last = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(32'(width_ff) - 32'd1);
      end
      if (height_ff == 11'd0) begin
         h_last = 10'd0;
      end else if (height_ff > 11'd1024) begin
         h_last = 10'd1023;
      end else begin
         h_last = 10'(height_ff - 11'd1);
      end
   end

   assign row_col_c = (col_ff > w_last) ? w_last : col_ff;
   assign row_c     = (row_ff > h_last) ? h_last : row_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Row store: read at accept, written back in the next cycle (ST_READ).
   always_ff @(posedge clock) begin
      if (req_take) begin
         above_ff <= row_mem[row_col_c];
      end
      if (state_ff == ST_READ) begin
         row_mem[c_ff] <= sample_ff;
      end
   end

   always_comb begin
      if (pending_ff[0]) begin
         pick = 2'd0;
      end else if (pending_ff[1]) begin
         pick = 2'd1;
      end else if (pending_ff[2]) begin
         pick = 2'd2;
      end else begin
         pick = 2'd3;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_READ;
         ST_READ:   state_in = ST_SEL;
         ST_SEL:    state_in = (pending_ff == '0) ? ST_IDLE : ST_PREP1;
         ST_PREP1:  state_in = ST_PREP2;
         ST_PREP2:  state_in = ST_SEARCH;
         ST_SEARCH: if (step_ff == 3'd0) state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_SEL;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= 11'd1024;
         height_ff    <= 11'd1024;
         col_ff       <= '0;
         row_ff       <= '0;
         left_cur_ff  <= '0;
         left_prev_ff <= '0;
         pending_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               default:    ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end
         if (state_ff == ST_READ) begin
            left_prev_ff <= above_ff;
            left_cur_ff  <= sample_ff;
            if (c_ff == w_last) begin
               col_ff <= '0;
               row_ff <= (r_ff == h_last) ? 10'd0 : r_ff + 10'd1;
            end else begin
               col_ff <= c_ff + CW'(1);
               row_ff <= r_ff;
            end
            pending_ff[0] <= (r_ff != 10'd0) && (c_ff != '0);
            pending_ff[1] <= (r_ff != 10'd0) && (c_ff == w_last);
            pending_ff[2] <= (r_ff == h_last) && (c_ff != '0);
            pending_ff[3] <= (r_ff == h_last) && (c_ff == w_last);
         end else if (state_ff == ST_SEL && pending_ff != '0) begin
            pending_ff[pick] <= 1'b0;
         end
      end
   end

   // Item capture and the candidate pixels it finishes.
   always_ff @(posedge clock) begin
      if (req_take) begin
         c_ff      <= row_col_c;
         r_ff      <= row_c;
         sample_ff <= req_height_sample;
      end
      if (state_ff == ST_READ) begin
         // Pixel left of this one in the row above.
         jobs_ff[0] <= '{pix_x: 10'(32'(c_ff) - 32'd1), pix_y: r_ff - 10'd1,
                         last: 1'b0, self_h: left_prev_ff, right_h: above_ff,
                         below_h: left_cur_ff};
         // Pixel above, at the end of the row.
         jobs_ff[1] <= '{pix_x: 10'(32'(c_ff)), pix_y: r_ff - 10'd1,
                         last: 1'b0, self_h: above_ff, right_h: above_ff,
                         below_h: sample_ff};
         // Last row: the pixel to the left, then this one at the row end.
         jobs_ff[2] <= '{pix_x: 10'(32'(c_ff) - 32'd1), pix_y: r_ff,
                         last: 1'b0, self_h: left_cur_ff, right_h: sample_ff,
                         below_h: left_cur_ff};
         jobs_ff[3] <= '{pix_x: 10'(32'(c_ff)), pix_y: r_ff,
                         last: 1'b1, self_h: sample_ff, right_h: sample_ff,
                         below_h: sample_ff};
      end
      if (state_ff == ST_SEL) begin
         cur_ff <= jobs_ff[pick];
      end
   end

   assign dx = $signed({1'b0, cur_ff.right_h}) - $signed({1'b0, cur_ff.self_h});
   assign dy = $signed({1'b0, cur_ff.below_h}) - $signed({1'b0, cur_ff.self_h});
   // floor(p / 255) for p below 65535.
   assign alpha_p = 16'(cur_ff.self_h) * 16'd127;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cand_sq[i] = accsq_ff[i] + (16'(acc_ff[i]) << (step_ff + 3'd1))
                    + (16'd1 << {step_ff, 1'b0});
         if (neg_ff[i]) begin
            cand_ok[i] = (34'(cand_sq[i]) * 34'(s_ff)) < 34'(nn_ff[i]);
         end else begin
            cand_ok[i] = (34'(cand_sq[i]) * 34'(s_ff)) <= 34'(nn_ff[i]);
         end
         if (neg_ff[i]) begin
            chan[i] = 8'd128 - (acc_ff[i] + 8'd1);
         end else begin
            chan[i] = 8'd128 + acc_ff[i];
         end
      end
   end

   // Per-pixel arithmetic: setup, then a bit-serial search for
   // floor(127 * d / sqrt(s)) on each channel.
   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP1) begin
         dx2_ff   <= 17'(dx * dx);
         dy2_ff   <= 17'(dy * dy);
         mr_ff    <= 15'(9'(dx[8] ? -dx : dx)) * 15'd127;
         mg_ff    <= 15'(9'(dy[8] ? -dy : dy)) * 15'd127;
         neg_ff[0] <= (dx > 9'sd0);
         neg_ff[1] <= (dy > 9'sd0);
         neg_ff[2] <= 1'b0;
         alpha_ff <= 8'((alpha_p + (alpha_p >> 8) + 16'd1) >> 8);
      end
      if (state_ff == ST_PREP2) begin
         s_ff     <= 18'(dx2_ff) + 18'(dy2_ff) + Z_SQ;
         nn_ff[0] <= 30'(mr_ff) * 30'(mr_ff);
         nn_ff[1] <= 30'(mg_ff) * 30'(mg_ff);
         nn_ff[2] <= BLUE_NUM_SQ;
         step_ff  <= 3'd7;
         for (int i = 0; i < 3; i++) begin
            acc_ff[i]   <= '0;
            accsq_ff[i] <= '0;
         end
      end
      if (state_ff == ST_SEARCH) begin
         step_ff <= step_ff - 3'd1;
         for (int i = 0; i < 3; i++) begin
            if (cand_ok[i]) begin
               acc_ff[i]   <= acc_ff[i] | (8'd1 << step_ff);
               accsq_ff[i] <= cand_sq[i];
            end
         end
      end
   end

   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_pixel_x     = cur_ff.pix_x;
   assign rsp_pixel_y     = cur_ff.pix_y;
   assign rsp_frame_done  = cur_ff.last;
   assign rsp_normal_argb = {alpha_ff, chan[0], chan[1], chan[2]};

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_READ)
      else $error("accepted item did not enter the row store read");

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && step_ff == 3'd0) |=> state_ff == ST_OUT)
      else $error("search did not finish after its last step");

   a_out_from_sel: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_stall) |=> state_ff == ST_SEL)
      else $error("delivered pixel did not return to dispatch");

   a_pending_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL && pending_ff == '0) |=> state_ff == ST_IDLE)
      else $error("dispatch with no pending pixel did not go idle");

endmodule
`default_nettype wire

// ===== test/tb_heightmap_to_normal_map_core.sv =====
`timescale 1ns / 1ps
module tb_heightmap_to_normal_map_core;
   import hmn_pkg::*;

   // One expected normal pixel.
   typedef struct {
      logic [9:0]  px;
      logic [9:0]  py;
      logic [31:0] argb;
      logic        done;
   } normal_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_height_sample = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [9:0]  rsp_pixel_x;
   logic [9:0]  rsp_pixel_y;
   logic [31:0] rsp_normal_argb;
   logic        rsp_frame_done;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_WIDTH;
   logic [10:0] csr_data = 11'd0;

   heightmap_to_normal_map_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Heights waiting to be offered, and normal pixels waiting to arrive.
   logic [7:0]   heights_pending[$];
   normal_item_type normals_expected[$];
   int           error_count = 0;
   int           normals_seen = 0;
   // While calm is set neither side idles.
   bit           calm = 1'b0;
   // While hold_on is set the receiver stalls every cycle.
   bit           hold_on = 1'b0;

   // Shadow of the block's state and size registers.
   logic [7:0]  store_shadow[1024];
   logic [7:0]  left_cur_sh;
   logic [7:0]  left_prev_sh;
   int unsigned col_sh;
   int unsigned row_sh;
   logic [10:0] width_reg;
   logic [10:0] height_reg;

   // floor(n / sqrt(s)), exact, by integer comparison.
   function automatic int floor_over_sqrt(int n, longint unsigned s);
      int k;
      longint unsigned mm;
      k = 0;
      mm = (n >= 0) ? longint'(n) * longint'(n) : longint'(-n) * longint'(-n);
      if (n >= 0) begin
         while (k < 255 && longint'(k + 1) * longint'(k + 1) * s <= mm) k++;
         return k;
      end
      while (k < 255 && longint'(k) * longint'(k) * s < mm) k++;
      return -k;
   endfunction

   function automatic logic [31:0] normal_word(logic [7:0] self_h, logic [7:0] right_h,
                                               logic [7:0] below_h);
      int dx;
      int dy;
      longint unsigned s;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] a;
      dx = int'(right_h) - int'(self_h);
      dy = int'(below_h) - int'(self_h);
      s = longint'(dx * dx) + longint'(dy * dy) + 65025;
      r = 8'(128 + floor_over_sqrt(-127 * dx, s));
      g = 8'(128 + floor_over_sqrt(-127 * dy, s));
      b = 8'(128 + floor_over_sqrt(127 * 255, s));
      a = 8'((127 * int'(self_h)) / 255);
      return {a, r, g, b};
   endfunction

   function automatic int unsigned eff_size(logic [10:0] v);
      if (v == 0) return 1;
      if (v > 1024) return 1024;
      return v;
   endfunction

   task automatic push_normal(int unsigned x, int unsigned y, logic [31:0] argb,
                              int unsigned w, int unsigned h);
      normal_item_type n;
      n.px = x[9:0];
      n.py = y[9:0];
      n.argb = argb;
      n.done = (x == w - 1 && y == h - 1);
      normals_expected.push_back(n);
   endtask

   // Advance the shadow state by one accepted height and queue its pixels.
   task automatic predict_height(logic [7:0] smp);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [7:0]  above;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      c = (col_sh >= w) ? w - 1 : col_sh;
      r = (row_sh >= h) ? h - 1 : row_sh;
      above = store_shadow[c];
      if (r >= 1) begin
         if (c >= 1) push_normal(c - 1, r - 1, normal_word(left_prev_sh, above, left_cur_sh), w, h);
         if (c == w - 1) push_normal(c, r - 1, normal_word(above, above, smp), w, h);
      end
      if (r == h - 1) begin
         if (c >= 1) push_normal(c - 1, r, normal_word(left_cur_sh, smp, left_cur_sh), w, h);
         if (c == w - 1) push_normal(c, r, normal_word(smp, smp, smp), w, h);
      end
      left_prev_sh = above;
      store_shadow[c] = smp;
      left_cur_sh = smp;
      if (c + 1 >= w) begin
         col_sh = 0;
         row_sh = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_sh = c + 1;
         row_sh = r;
      end
   endtask

   // Driver: predicts on each accepted item, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_height(req_height_sample);
         if (!req_valid || !req_stall) begin
            if (heights_pending.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
               req_valid <= 1'b1;
               req_height_sample <= heights_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted item with the oldest expectation and
   // drives the stall.
   always @(posedge clock) begin
      normal_item_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            normals_seen++;
            if (normals_expected.size() == 0) begin
               $error("unexpected normal item x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
               error_count++;
            end else begin
               e = normals_expected.pop_front();
               if (rsp_pixel_x !== e.px) begin
                  $error("pixel_x expected %0d got %0d", e.px, rsp_pixel_x);
                  error_count++;
               end
               if (rsp_pixel_y !== e.py) begin
                  $error("pixel_y expected %0d got %0d", e.py, rsp_pixel_y);
                  error_count++;
               end
               if (rsp_normal_argb !== e.argb) begin
                  $error("normal_argb expected %h got %h", e.argb, rsp_normal_argb);
                  error_count++;
               end
               if (rsp_frame_done !== e.done) begin
                  $error("frame_done expected %0d got %0d", e.done, rsp_frame_done);
                  error_count++;
               end
            end
         end
         if (hold_on) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);
         end
      end
   end

   // One long hold-off, started once plenty of heights are queued, so the
   // block fills up and stalls its input while the driver keeps offering.
   initial begin
      do @(posedge clock); while (heights_pending.size() <= 20);
      hold_on <= 1'b1;
      repeat (600) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Waits until every item is in and out, then lets the block go quiet.
   task automatic settle();
      while (heights_pending.size() > 0 || req_valid || normals_expected.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Drives one register write and mirrors it in the shadow state; the caller drops csr_write.
   task automatic write_reg(logic idx, logic [10:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      if (idx == CSR_WIDTH) width_reg = val;
      else height_reg = val;
      col_sh = 0;
      row_sh = 0;
   endtask

   // One phase: let the block settle, set the size, then feed the given number of heights.
   task automatic run_phase(logic [10:0] w, logic [10:0] h, int count, bit extremes);
      settle();
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      csr_write <= 1'b0;
      for (int i = 0; i < count; i++) begin
         if (extremes) heights_pending.push_back((i % 3 == 0) ? 8'd0 :
                                                 (i % 3 == 1) ? 8'd255 : 8'($urandom));
         else heights_pending.push_back(8'($urandom));
      end
   endtask

   initial begin
      int fed;
      int unsigned ew;
      int unsigned eh;
      int cnt;
      logic [10:0] w;
      logic [10:0] h;
      foreach (store_shadow[i]) store_shadow[i] = 8'd0;
      left_cur_sh = 8'd0;
      left_prev_sh = 8'd0;
      col_sh = 0;
      row_sh = 0;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: the smallest image, out-of-range sizes that clamp, a
      // single long row, and steep edges between the height extremes, then
      // one frame and a bit that queues enough heights for the long hold-off.
      run_phase(11'd1, 11'd1, 3, 1'b1);
      run_phase(11'd0, 11'd0, 3, 1'b1);
      run_phase(11'd2047, 11'd1, 6, 1'b1);
      run_phase(11'd3, 11'd2, 6, 1'b1);
      run_phase(11'd1, 11'd2047, 5, 1'b1);
      run_phase(11'd6, 11'd4, 30, 1'b0);
      fed = 53;

      // Random: mostly whole frames of small sizes, some running into the
      // next frame and some cut short by the next size change.
      while (fed < 270) begin
         w = 11'($urandom_range(1, 8));
         h = 11'($urandom_range(1, 5));
         case ($urandom_range(9))
            0: w = 11'd0;
            1: h = 11'd0;
            2: begin
               w = 11'(1024 + $urandom_range(0, 1023));
               h = 11'd1;
            end
            default: ;
         endcase
         ew = eff_size(w);
         eh = eff_size(h);
         if (ew * eh > 64) cnt = $urandom_range(10, 40);
         else if ($urandom_range(3) == 0) cnt = $urandom_range(1, ew * eh);
         else if ($urandom_range(3) == 0) cnt = ew * eh + $urandom_range(1, ew * eh);
         else cnt = ew * eh;
         calm = (fed >= 120 && fed < 180);
         run_phase(w, h, cnt, 1'b0);
         fed += cnt;
      end
      settle();
      calm = 1'b0;
      repeat (100) @(posedge clock);
      if (error_count == 0 && normals_expected.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #8ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
